[src/bch_pkg.sv]
package bch_pkg;

    localparam int CODE_N  = 15;
    localparam int TOP_POS = 14;
    localparam int MSG_K   = 7;
    localparam logic [4:0] GF_POLY = 5'd19;

    typedef logic [3:0] gf_t;

    typedef enum logic [1:0] {
        CLS_CLEAN  = 2'd0,
        CLS_SINGLE = 2'd1,
        CLS_DOUBLE = 2'd2,
        CLS_FAIL   = 2'd3
    } cls_t;

    localparam logic [1:0] ST_CLEAN  = 2'd0;
    localparam logic [1:0] ST_ONE    = 2'd1;
    localparam logic [1:0] ST_TWO    = 2'd2;
    localparam logic [1:0] ST_UNCORR = 2'd3;

    typedef struct packed {
        logic [CODE_N-1:0] word;
        gf_t               s1;
        gf_t               sig2;
        cls_t              cls;
    } q_item_t;

    function automatic gf_t gf_mul(input gf_t a, input gf_t b);
        gf_t p;
        gf_t x;
        p = '0;
        x = a;
        for (int i = 0; i < 4; i++)
        begin
            if (b[i])
            begin
                p = p ^ x;
            end
            x = {x[2:0], 1'b0} ^ (x[3] ? GF_POLY[3:0] : 4'd0);
        end
        return p;
    endfunction

    // alpha^k, k in 0..CODE_N-1
    function automatic gf_t gf_pow(input int k);
        gf_t p;
        p = 4'd1;
        for (int i = 0; i < CODE_N; i++)
        begin
            if (i < k)
            begin
                p = gf_mul(p, 4'd2);
            end
        end
        return p;
    endfunction

    function automatic gf_t gf_inv(input gf_t a);
        gf_t r;
        case (a)
            4'd1:    r = 4'd1;
            4'd2:    r = 4'd9;
            4'd3:    r = 4'd14;
            4'd4:    r = 4'd13;
            4'd5:    r = 4'd11;
            4'd6:    r = 4'd7;
            4'd7:    r = 4'd6;
            4'd8:    r = 4'd15;
            4'd9:    r = 4'd2;
            4'd10:   r = 4'd12;
            4'd11:   r = 4'd5;
            4'd12:   r = 4'd10;
            4'd13:   r = 4'd4;
            4'd14:   r = 4'd3;
            4'd15:   r = 4'd8;
            default: r = 4'd0;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] gf_log(input gf_t a);
        logic [3:0] r;
        case (a)
            4'd2:    r = 4'd1;
            4'd3:    r = 4'd4;
            4'd4:    r = 4'd2;
            4'd5:    r = 4'd8;
            4'd6:    r = 4'd5;
            4'd7:    r = 4'd10;
            4'd8:    r = 4'd3;
            4'd9:    r = 4'd14;
            4'd10:   r = 4'd9;
            4'd11:   r = 4'd7;
            4'd12:   r = 4'd6;
            4'd13:   r = 4'd13;
            4'd14:   r = 4'd11;
            4'd15:   r = 4'd12;
            default: r = 4'd0;
        endcase
        return r;
    endfunction

endpackage

[src/bch_front.sv]
module bch_front
    import bch_pkg::*;
(
    input  logic              start,
    input  logic              full,
    input  logic [CODE_N-1:0] received_word,
    output logic              push,
    output q_item_t           item
);

    gf_t s1;
    gf_t s3;
    gf_t s1_cube;
    gf_t delta;

    always_comb
    begin
        s1 = '0;
        s3 = '0;
        for (int b = 0; b < CODE_N; b++)
        begin
            if (received_word[b])
            begin
                s1 = s1 ^ gf_pow(b);
                s3 = s3 ^ gf_pow((3 * b) % CODE_N);
            end
        end
    end

    assign s1_cube = gf_mul(gf_mul(s1, s1), s1);
    assign delta   = s3 ^ s1_cube;

    always_comb
    begin
        item.word = received_word;
        item.s1   = s1;
        item.sig2 = gf_mul(delta, gf_inv(s1));
        if (s1 == 4'd0 && s3 == 4'd0)
        begin
            item.cls = CLS_CLEAN;
        end
        else if (s1 == 4'd0)
        begin
            item.cls = CLS_FAIL;
        end
        else if (delta == 4'd0)
        begin
            item.cls = CLS_SINGLE;
        end
        else
        begin
            item.cls = CLS_DOUBLE;
        end
    end

    assign push = start && !full;

endmodule

[src/bch_queue.sv]
module bch_queue
    import bch_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  q_item_t push_item,
    input  logic    pop,
    output q_item_t head,
    output logic    empty,
    output logic    full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    q_item_t       mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == CW'(DEPTH));
    assign head  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue read while empty");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count lost a push");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (empty || full) |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointers out of step");

endmodule

[src/bch_back.sv]
module bch_back
    import bch_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             empty,
    input  q_item_t          head,
    output logic             pop,
    output logic             valid,
    output logic [MSG_K-1:0] message,
    output logic [1:0]       status
);

    logic [CODE_N-1:0] roots;
    logic [CODE_N-1:0] fixed;
    logic [3:0]        nroots;
    logic [1:0]        st;
    logic              valid_reg;
    logic [MSG_K-1:0]  message_reg, message_next;
    logic [1:0]        status_reg;

    // Chien search: locator at alpha^-j
    always_comb
    begin
        for (int j = 0; j < CODE_N; j++)
        begin
            roots[j] = ((4'd1
                ^ gf_mul(head.s1, gf_pow((CODE_N - j) % CODE_N))
                ^ gf_mul(head.sig2, gf_mul(gf_pow((CODE_N - j) % CODE_N),
                                           gf_pow((CODE_N - j) % CODE_N))))
                == 4'd0);
        end
    end

    assign nroots = 4'($countones(roots));

    always_comb
    begin
        fixed = head.word;
        st    = ST_CLEAN;
        case (head.cls)
            CLS_CLEAN:
            begin
                st = ST_CLEAN;
            end
            CLS_SINGLE:
            begin
                fixed = head.word ^ (CODE_N'(1) << gf_log(head.s1));
                st    = ST_ONE;
            end
            CLS_DOUBLE:
            begin
                fixed = head.word ^ roots;
                if (nroots == 4'd0)
                begin
                    st = ST_UNCORR;
                end
                else if (nroots > 4'd2)
                begin
                    st = ST_TWO;
                end
                else
                begin
                    st = nroots[1:0];
                end
            end
            default:
            begin
                st = ST_UNCORR;
            end
        endcase
    end

    assign message_next = fixed[TOP_POS -: MSG_K];
    assign pop          = !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= pop;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            message_reg <= message_next;
            status_reg  <= st;
        end
    end

    assign valid   = valid_reg;
    assign message = message_reg;
    assign status  = status_reg;

endmodule

[src/bch_15_7_double_error_decoder.sv]
// BCH(15,7) double-error decoder, GF(16) with x^4+x+1.
// An accepted item is written into the queue, then popped into the output registers; valid is registered with them.
// One item per cycle while busy is low; the back end pops whenever the queue is not empty.
// busy rises only if the item queue fills, which the back end never allows when QUEUE_DEPTH is at least 2.
// rst_n (async, active low) empties the queue and clears valid.
module bch_15_7_double_error_decoder
    import bch_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [CODE_N-1:0] received_word,
    output logic              valid,
    output logic [MSG_K-1:0]  message,
    output logic [1:0]        status
);

    logic    push;
    logic    pop;
    logic    empty;
    logic    full;
    q_item_t push_item;
    q_item_t head;

    assign busy = full;

    bch_front u_front
    (
        .start         (start),
        .full          (full),
        .received_word (received_word),
        .push          (push),
        .item          (push_item)
    );

    bch_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .empty     (empty),
        .full      (full)
    );

    bch_back u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .empty   (empty),
        .head    (head),
        .pop     (pop),
        .valid   (valid),
        .message (message),
        .status  (status)
    );

endmodule
